FILE: rtl/trp_pkg.sv
// ============================================================================
// trp_pkg
// Shared widths, codes, types and helpers of the trapezoid ramp generator.
// ============================================================================
package trp_pkg;

    // Width of the stored profile speed.
    localparam int SPEED_WIDTH  = 20;

    // Field and register widths.
    localparam int DIST_W       = 22;
    localparam int CFG_SPEED_W  = 20;
    localparam int STEP_W       = 16;
    localparam int RATE_W       = 16;
    localparam int STOPD_W      = 16;
    localparam int OUT_SPEED_W  = 20;
    localparam int ZONE_W       = 2;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 20;
    localparam int IN_TDATA_W   = 24;
    localparam int OUT_TDATA_W  = 24;

    // Speed arithmetic is done one bit wider than the widest speed operand so
    // that a speed plus a step never wraps.
    localparam int CALC_W = ((SPEED_WIDTH > CFG_SPEED_W) ? SPEED_WIDTH : CFG_SPEED_W) + 1;

    // Braking test: distance * rate * 512 against speed squared.
    localparam int PROD_W    = (DIST_W - 1) + RATE_W;
    localparam int LHS_SHIFT = 9;
    localparam int LHS_W     = PROD_W + LHS_SHIFT;
    localparam int SQ_W      = 2 * SPEED_WIDTH;
    localparam int CMP_W     = (LHS_W > SQ_W) ? LHS_W : SQ_W;

    localparam logic [CALC_W-1:0] SPEED_MAX =
        {{(CALC_W - SPEED_WIDTH){1'b0}}, {SPEED_WIDTH{1'b1}}};

    // Register reset values.
    localparam logic [CFG_SPEED_W-1:0] CRUISE_SPEED_RST  = '0;
    localparam logic [STEP_W-1:0]      ACCEL_STEP_RST    = '0;
    localparam logic [STEP_W-1:0]      DECEL_STEP_RST    = '0;
    localparam logic [RATE_W-1:0]      DECEL_RATE_RST    = RATE_W'(1);
    localparam logic [CFG_SPEED_W-1:0] CREEP_SPEED_RST   = '0;
    localparam logic [STOPD_W-1:0]     STOP_DISTANCE_RST = STOPD_W'(512);

    typedef enum logic [ZONE_W-1:0] {
        ZONE_STOP   = 2'd0,
        ZONE_BRAKE  = 2'd1,
        ZONE_ACCEL  = 2'd2,
        ZONE_CRUISE = 2'd3
    } t_zone;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CRUISE_SPEED  = 3'd0,
        CFG_ACCEL_STEP    = 3'd1,
        CFG_DECEL_STEP    = 3'd2,
        CFG_DECEL_RATE    = 3'd3,
        CFG_CREEP_SPEED   = 3'd4,
        CFG_STOP_DISTANCE = 3'd5
    } t_cfg_idx;

    typedef struct packed {
        logic [CFG_SPEED_W-1:0] cruise_speed;
        logic [STEP_W-1:0]      accel_step;
        logic [STEP_W-1:0]      decel_step;
        logic [RATE_W-1:0]      decel_rate;
        logic [CFG_SPEED_W-1:0] creep_speed;
        logic [STOPD_W-1:0]     stop_distance;
    } t_cfg;

    // One item held in the input register, with its distance already
    // multiplied by the deceleration rate.
    typedef struct packed {
        logic signed [DIST_W-1:0] rem_dist;
        logic                     restart;
        logic [PROD_W-1:0]        dist_rate;
    } t_item;

    // Clamp a speed to the stored width.
    function automatic logic [SPEED_WIDTH-1:0] sat_speed(input logic [CALC_W-1:0] v);
        logic [SPEED_WIDTH-1:0] res;
        if (v > SPEED_MAX) begin
            res = {SPEED_WIDTH{1'b1}};
        end else begin
            res = v[SPEED_WIDTH-1:0];
        end
        return res;
    endfunction

endpackage

FILE: rtl/trapezoid_ramp_generator.sv
// ============================================================================
// trapezoid_ramp_generator
// Trapezoidal speed profile: one ramp step per control tick item.
// ============================================================================
// Each input item carries the signed distance still to go (Q.8 mm) and a
// restart flag; each item gives exactly one result item with the new profile
// speed (Q.8 mm/s), the zone (stop, brake, accelerate, cruise) and a done
// flag, in input order. The block takes one item per clock cycle while the
// output takes its results. The edge that accepts an item registers it
// together with distance times deceleration rate; from that register the
// stored speed is squared and compared against the product, the zone is
// picked, and the new speed is stored next to the result register at the
// edge that moves the item on. A result thus passes the input register and
// then the result register on its way to the output. That second stage,
// with its speed feedback from one item to the next, sets the cycle time.
// The input side keeps accepting while a finished result waits on the
// output, and backpressure from the output reaches the input only when
// both registers are full. Registers may be rewritten at any time the
// configuration channel is valid (it is always ready), but should only
// change while no item is in flight. There is no clearing pass after reset.
// ============================================================================
module trapezoid_ramp_generator (
    input  logic                            i_clk,
    input  logic                            i_rst_n,

    input  logic                            s_axis_tvalid,
    output logic                            s_axis_tready,
    // [21:0] remaining_distance (signed), [23:22] zero
    input  logic [trp_pkg::IN_TDATA_W-1:0]  s_axis_tdata,
    // [0] restart
    input  logic                            s_axis_tuser,

    output logic                            m_axis_tvalid,
    input  logic                            m_axis_tready,
    // [19:0] profile_speed, [21:20] zone, [22] move_done, [23] zero
    output logic [trp_pkg::OUT_TDATA_W-1:0] m_axis_tdata,

    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [trp_pkg::CFG_IDX_W-1:0]   i_cfg_index,
    input  logic [trp_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import trp_pkg::*;

    t_cfg                   cfg;
    t_item                  item;
    logic                   item_valid;
    logic                   advance;
    logic [OUT_SPEED_W-1:0] out_speed;
    t_zone                  out_zone;
    logic                   out_done;

    // The register file accepts a write in every cycle.
    assign o_cfg_ready = 1'b1;

    trp_cfg_regs u_cfg_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    trp_in_stage u_in_stage (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (s_axis_tvalid),
        .o_ready      (s_axis_tready),
        .i_dist       (s_axis_tdata[DIST_W-1:0]),
        .i_restart    (s_axis_tuser),
        .i_rate       (cfg.decel_rate),
        .i_advance    (advance),
        .o_item_valid (item_valid),
        .o_item       (item)
    );

    trp_speed_core u_speed_core (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item_valid (item_valid),
        .i_item       (item),
        .i_cfg        (cfg),
        .o_advance    (advance),
        .i_out_ready  (m_axis_tready),
        .o_out_valid  (m_axis_tvalid),
        .o_speed      (out_speed),
        .o_zone       (out_zone),
        .o_done       (out_done)
    );

    // Results are packed with the speed in the low bits.
    assign m_axis_tdata = {
        {(OUT_TDATA_W - OUT_SPEED_W - ZONE_W - 1){1'b0}},
        out_done,
        out_zone,
        out_speed
    };

endmodule

FILE: rtl/trp_cfg_regs.sv
// ============================================================================
// trp_cfg_regs
// Configuration register file of the trapezoid ramp generator.
// ============================================================================
module trp_cfg_regs (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_cfg_valid,
    input  logic [trp_pkg::CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [trp_pkg::CFG_DATA_W-1:0] i_cfg_data,
    output trp_pkg::t_cfg                  o_cfg
);
    import trp_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.cruise_speed  <= CRUISE_SPEED_RST;
            r_cfg.accel_step    <= ACCEL_STEP_RST;
            r_cfg.decel_step    <= DECEL_STEP_RST;
            r_cfg.decel_rate    <= DECEL_RATE_RST;
            r_cfg.creep_speed   <= CREEP_SPEED_RST;
            r_cfg.stop_distance <= STOP_DISTANCE_RST;
        end else if (i_cfg_valid) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_CRUISE_SPEED:  r_cfg.cruise_speed  <= i_cfg_data[CFG_SPEED_W-1:0];
                CFG_ACCEL_STEP:    r_cfg.accel_step    <= i_cfg_data[STEP_W-1:0];
                CFG_DECEL_STEP:    r_cfg.decel_step    <= i_cfg_data[STEP_W-1:0];
                CFG_DECEL_RATE:    r_cfg.decel_rate    <= i_cfg_data[RATE_W-1:0];
                CFG_CREEP_SPEED:   r_cfg.creep_speed   <= i_cfg_data[CFG_SPEED_W-1:0];
                CFG_STOP_DISTANCE: r_cfg.stop_distance <= i_cfg_data[STOPD_W-1:0];
                default: begin
                    // Writes to unused indexes are dropped.
                end
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

FILE: rtl/trp_in_stage.sv
// ============================================================================
// trp_in_stage
// Input register; forms distance times deceleration rate on the way in.
// ============================================================================
module trp_in_stage (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_valid,
    output logic                       o_ready,
    input  logic [trp_pkg::DIST_W-1:0] i_dist,
    input  logic                       i_restart,
    input  logic [trp_pkg::RATE_W-1:0] i_rate,
    input  logic                       i_advance,
    output logic                       o_item_valid,
    output trp_pkg::t_item             o_item
);
    import trp_pkg::*;

    logic  r_valid;
    t_item r_item;
    t_item n_item;
    logic  accept;

    assign o_ready = !r_valid || i_advance;
    assign accept  = i_valid && o_ready;

    // The product only matters when the distance is positive, so the sign
    // bit is left out of the multiply.
    always_comb begin
        n_item.rem_dist  = signed'(i_dist);
        n_item.restart   = i_restart;
        n_item.dist_rate = PROD_W'(i_dist[DIST_W-2:0]) * PROD_W'(i_rate);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_advance) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= n_item;
        end
    end

    assign o_item_valid = r_valid;
    assign o_item       = r_item;

endmodule

FILE: rtl/trp_speed_core.sv
// ============================================================================
// trp_speed_core
// Zone decision, stored profile speed and result register.
// ============================================================================
module trp_speed_core (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_item_valid,
    input  trp_pkg::t_item                  i_item,
    input  trp_pkg::t_cfg                   i_cfg,
    output logic                            o_advance,
    input  logic                            i_out_ready,
    output logic                            o_out_valid,
    output logic [trp_pkg::OUT_SPEED_W-1:0] o_speed,
    output trp_pkg::t_zone                  o_zone,
    output logic                            o_done
);
    import trp_pkg::*;

    logic [SPEED_WIDTH-1:0] r_speed;
    logic                   r_out_valid;
    logic [OUT_SPEED_W-1:0] r_out_speed;
    t_zone                  r_out_zone;
    logic                   r_out_done;

    logic [SPEED_WIDTH-1:0] cur_speed;
    logic [CALC_W-1:0]      cur_ext;
    logic signed [DIST_W:0] dist_ext;
    logic signed [DIST_W:0] stop_ext;
    logic                   stop_hit;
    logic [SQ_W-1:0]        speed_sq;
    logic [LHS_W-1:0]       brake_lhs;
    logic                   brake_hit;
    logic [CALC_W-1:0]      target_ext;
    logic [CALC_W-1:0]      creep_ext;
    logic [CALC_W-1:0]      brake_floor;
    logic [CALC_W-1:0]      accel_sum;
    logic [CALC_W-1:0]      n_calc;
    t_zone                  n_zone;
    logic [SPEED_WIDTH-1:0] n_speed;
    logic [CALC_W-1:0]      n_speed_ext;
    logic [CALC_W-1:0]      r_speed_ext;

    assign o_advance = i_item_valid && (!r_out_valid || i_out_ready);

    always_comb begin
        cur_speed   = i_item.restart ? '0 : r_speed;
        cur_ext     = CALC_W'(cur_speed);
        dist_ext    = {i_item.rem_dist[DIST_W-1], i_item.rem_dist};
        stop_ext    = signed'((DIST_W + 1)'(i_cfg.stop_distance));
        stop_hit    = dist_ext <= stop_ext;
        speed_sq    = SQ_W'(cur_speed) * SQ_W'(cur_speed);
        brake_lhs   = {i_item.dist_rate, {LHS_SHIFT{1'b0}}};
        brake_hit   = CMP_W'(brake_lhs) <= CMP_W'(speed_sq);
        target_ext  = CALC_W'(i_cfg.cruise_speed);
        creep_ext   = CALC_W'(i_cfg.creep_speed);
        brake_floor = creep_ext + CALC_W'(i_cfg.decel_step);
        accel_sum   = cur_ext + CALC_W'(i_cfg.accel_step);

        if (stop_hit) begin
            n_calc = '0;
            n_zone = ZONE_STOP;
        end else if (brake_hit) begin
            // Taking the step off would land below the creep floor.
            if (cur_ext < brake_floor) begin
                n_calc = creep_ext;
            end else begin
                n_calc = cur_ext - CALC_W'(i_cfg.decel_step);
            end
            n_zone = ZONE_BRAKE;
        end else if (cur_ext < target_ext) begin
            n_calc = (accel_sum > target_ext) ? target_ext : accel_sum;
            n_zone = ZONE_ACCEL;
        end else begin
            n_calc = target_ext;
            n_zone = ZONE_CRUISE;
        end

        n_speed     = sat_speed(n_calc);
        n_speed_ext = CALC_W'(n_speed);
        r_speed_ext = CALC_W'(r_speed);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_speed     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_advance) begin
                r_speed     <= n_speed;
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_advance) begin
            r_out_speed <= n_speed_ext[OUT_SPEED_W-1:0];
            r_out_zone  <= n_zone;
            r_out_done  <= stop_hit;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_speed     = r_out_speed;
    assign o_zone      = r_out_zone;
    assign o_done      = r_out_done;

    a_done_is_stop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out_done == (r_out_zone == ZONE_STOP)))
        else $error("done flag disagrees with stop zone");

    a_stop_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zone == ZONE_STOP) |-> (r_out_speed == '0))
        else $error("stop zone with nonzero speed");

    a_accel_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zone == ZONE_ACCEL) |-> (r_speed_ext <= target_ext))
        else $error("acceleration passed the target speed");

    a_cruise_target: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_zone == ZONE_CRUISE) |-> (r_speed == sat_speed(target_ext)))
        else $error("cruise speed differs from target");

    a_state_matches_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_advance |=> (r_out_speed == r_speed_ext[OUT_SPEED_W-1:0]))
        else $error("stored speed and result speed differ");

endmodule

FILE: dv/tb_trapezoid_ramp_generator.sv
// ============================================================================
// tb_trapezoid_ramp_generator
// Self-checking testbench for the trapezoid ramp generator.
// ============================================================================
// Control tick items are queued by the stimulus process and fed to the input
// stream by a clocked driver. When the block accepts an item, the driver runs
// it through a ramp step predictor with its own copy of the registers and of
// the stored speed. The predicted speed, zone and done flag wait in a queue
// until a clocked monitor compares them with the next result item. A short
// directed part walks every zone and corner case. Randomized phases with
// several register settings, the extremes among them, then run whole moves
// from far away down to a stop, mixed with noise items.
// ============================================================================
module tb_trapezoid_ramp_generator;

    import trp_pkg::*;

    // Register indexes that the block does not decode; writes to them must
    // leave every register as it was.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam longint SPEED_CAP       = (longint'(1) << SPEED_WIDTH) - 1;
    localparam int     ITEMS_PER_PHASE = 160;
    localparam int     RANDOM_PHASES   = 9;
    localparam int     SETTLE_CYCLES   = 8;
    localparam int     WATCHDOG_LIMIT  = 3000;
    // The long output stall that backs the block up into its input.
    localparam int     PRESSURE_AT     = 300;
    localparam int     PRESSURE_LEN    = 120;

    typedef struct {
        logic [DIST_W-1:0] rem_dist;
        logic              restart;
    } tick_t;

    typedef struct {
        logic [OUT_SPEED_W-1:0] speed;
        t_zone                  zone;
        logic                   done;
    } ramp_out_t;

    logic                   i_clk;
    logic                   i_rst_n       = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata  = '0;
    logic                   s_axis_tuser  = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   i_cfg_valid   = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index   = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data    = '0;

    // Predictor copy of the registers, starting from their reset values.
    logic [CFG_SPEED_W-1:0] cfg_target  = CRUISE_SPEED_RST;
    logic [STEP_W-1:0]      cfg_accel   = ACCEL_STEP_RST;
    logic [STEP_W-1:0]      cfg_decel   = DECEL_STEP_RST;
    logic [RATE_W-1:0]      cfg_rate    = DECEL_RATE_RST;
    logic [CFG_SPEED_W-1:0] cfg_creep   = CREEP_SPEED_RST;
    logic [STOPD_W-1:0]     cfg_stop    = STOP_DISTANCE_RST;
    logic [SPEED_WIDTH-1:0] model_speed = '0;

    tick_t     tick_queue[$];
    ramp_out_t ramp_out_queue[$];
    tick_t     drv_tick;
    ramp_out_t exp_out;

    int n_errors     = 0;
    int stall_cycles = 0;
    int tx_gap       = 0;
    int rx_stall     = 0;
    int rx_count     = 0;
    bit pressure_done = 1'b0;
    bit tx_idle_on    = 1'b1;
    bit rx_idle_on    = 1'b1;

    trapezoid_ramp_generator dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        // [21:0] remaining_distance (signed), [23:22] zero
        .s_axis_tdata  (s_axis_tdata),
        // [0] restart
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        // [19:0] profile_speed, [21:20] zone, [22] move_done, [23] zero
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Length of the idle stretch after an item: mostly none, sometimes short
    // and now and then a long one.
    function automatic int idle_len(input bit enabled);
        int pick;
        if (!enabled) return 0;
        pick = $urandom_range(0, 99);
        if (pick < 12) return $urandom_range(1, 3);
        if (pick < 15) return $urandom_range(10, 40);
        return 0;
    endfunction

    // One ramp step: picks the zone from the distance and the stored speed,
    // stores the new speed and queues the result item that must follow.
    task automatic compute_ramp_step(input logic signed [DIST_W-1:0] rem,
                                     input logic restart);
        longint    r;
        longint    s;
        longint    cand;
        longint    ns;
        t_zone     zone;
        ramp_out_t res;
        r = longint'(rem);
        s = restart ? 0 : longint'(model_speed);
        if (r <= longint'(cfg_stop)) begin
            ns   = 0;
            zone = ZONE_STOP;
        end else if (r * 512 * longint'(cfg_rate) <= s * s) begin
            // The braking distance is compared against the remaining
            // distance by cross-multiplication. The creep floor applies even
            // when it lies above the current speed.
            cand = s - longint'(cfg_decel);
            ns   = (cand < longint'(cfg_creep)) ? longint'(cfg_creep) : cand;
            zone = ZONE_BRAKE;
        end else if (s < longint'(cfg_target)) begin
            ns = s + longint'(cfg_accel);
            if (ns > longint'(cfg_target)) ns = longint'(cfg_target);
            zone = ZONE_ACCEL;
        end else begin
            // Also taken when the target was lowered below the current speed.
            ns   = longint'(cfg_target);
            zone = ZONE_CRUISE;
        end
        if (ns > SPEED_CAP) ns = SPEED_CAP;
        model_speed = ns[SPEED_WIDTH-1:0];
        res.speed   = ns[OUT_SPEED_W-1:0];
        res.zone    = zone;
        res.done    = (ns == 0) && (r <= longint'(cfg_stop));
        ramp_out_queue.push_back(res);
    endtask

    // Input driver. The prediction is made at the edge where the item is
    // accepted, from the very values that stood on the bus.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
            tx_gap        <= 0;
        end else begin
            if (s_axis_tvalid && s_axis_tready) begin
                compute_ramp_step(s_axis_tdata[DIST_W-1:0], s_axis_tuser);
            end
            if (!s_axis_tvalid || s_axis_tready) begin
                if (tx_gap > 0) begin
                    s_axis_tvalid <= 1'b0;
                    tx_gap        <= tx_gap - 1;
                end else if (tick_queue.size() > 0) begin
                    drv_tick       = tick_queue.pop_front();
                    s_axis_tdata  <= {{(IN_TDATA_W - DIST_W){1'b0}}, drv_tick.rem_dist};
                    s_axis_tuser  <= drv_tick.restart;
                    s_axis_tvalid <= 1'b1;
                    tx_gap        <= idle_len(tx_idle_on);
                end else begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Output receiver. It counts its own results and once, after a fixed
    // number of them, holds ready low for a long stretch while the driver
    // keeps offering items, so that both pipeline registers fill and the
    // input side stalls.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
            rx_stall      <= 0;
        end else begin
            if (m_axis_tvalid && m_axis_tready) rx_count <= rx_count + 1;
            if (!pressure_done && rx_count >= PRESSURE_AT) begin
                pressure_done <= 1'b1;
                rx_stall      <= PRESSURE_LEN;
                m_axis_tready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall      <= rx_stall - 1;
                m_axis_tready <= 1'b0;
            end else begin
                m_axis_tready <= 1'b1;
                rx_stall      <= idle_len(rx_idle_on);
            end
        end
    end

    // Result monitor: every accepted result item is checked field by field
    // against the oldest predicted one.
    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (ramp_out_queue.size() == 0) begin
                $error("result item with no tick pending, tdata %0h", m_axis_tdata);
                n_errors++;
            end else begin
                exp_out = ramp_out_queue.pop_front();
                if (m_axis_tdata[19:0] !== exp_out.speed) begin
                    $error("profile_speed: expected %0h, got %0h",
                           exp_out.speed, m_axis_tdata[19:0]);
                    n_errors++;
                end
                if (m_axis_tdata[21:20] !== exp_out.zone) begin
                    $error("zone: expected %0d, got %0d", exp_out.zone, m_axis_tdata[21:20]);
                    n_errors++;
                end
                if (m_axis_tdata[22] !== exp_out.done) begin
                    $error("move_done: expected %0d, got %0d", exp_out.done, m_axis_tdata[22]);
                    n_errors++;
                end
            end
        end
    end

    // Cycles in a row in which no channel moved anything.
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
            (i_cfg_valid && o_cfg_ready)) begin
            stall_cycles <= 0;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        while (stall_cycles < WATCHDOG_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    task automatic queue_tick(input int rem, input bit restart);
        tick_t t;
        t.rem_dist = DIST_W'(rem);
        t.restart  = restart;
        tick_queue.push_back(t);
    endtask

    // One register write; the caller lowers valid after its last write so
    // that back-to-back writes keep valid high without a glitch.
    task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        case (idx)
            CFG_CRUISE_SPEED:  cfg_target = data[CFG_SPEED_W-1:0];
            CFG_ACCEL_STEP:    cfg_accel  = data[STEP_W-1:0];
            CFG_DECEL_STEP:    cfg_decel  = data[STEP_W-1:0];
            CFG_DECEL_RATE:    cfg_rate   = data[RATE_W-1:0];
            CFG_CREEP_SPEED:   cfg_creep  = data[CFG_SPEED_W-1:0];
            CFG_STOP_DISTANCE: cfg_stop   = data[STOPD_W-1:0];
            default: ;
        endcase
    endtask

    // Writes a whole profile. The unused upper data bits of the 16-bit
    // registers carry noise, and both undecoded indexes get a write too.
    task automatic program_profile(input int target, input int accel, input int decel,
                                   input int rate, input int creep, input int stopd);
        cfg_write(CFG_CRUISE_SPEED, CFG_DATA_W'(target));
        cfg_write(CFG_ACCEL_STEP, {4'($urandom), 16'(accel)});
        cfg_write(CFG_DECEL_STEP, {4'($urandom), 16'(decel)});
        cfg_write(CFG_DECEL_RATE, {4'($urandom), 16'(rate)});
        cfg_write(CFG_CREEP_SPEED, CFG_DATA_W'(creep));
        cfg_write(CFG_STOP_DISTANCE, {4'($urandom), 16'(stopd)});
        cfg_write(CFG_SPARE_LO, CFG_DATA_W'($urandom));
        cfg_write(CFG_SPARE_HI, CFG_DATA_W'($urandom));
        i_cfg_valid <= 1'b0;
    endtask

    // Returns once every queued tick has been accepted and answered and a
    // settling wait is over, so that the pipeline is surely empty before registers move.
    task automatic wait_idle;
        while (tick_queue.size() != 0 || s_axis_tvalid || ramp_out_queue.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly whole moves: a restart, then a distance that shrinks by a
    // fraction each tick, so the profile runs through accelerate, cruise,
    // brake and stop, and ends with a few ticks around the target. Some
    // moves jump back out, and some items are pure noise.
    task automatic queue_random_moves(input int count);
        int left;
        int span;
        int shrink;
        int tail;
        int near;
        bit first;
        left = count;
        while (left > 0) begin
            if ($urandom_range(0, 99) < 15) begin
                queue_tick(int'($urandom), 1'($urandom));
                left--;
            end else begin
                span   = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 2097151)
                                                     : $urandom_range(1000, 200000);
                shrink = $urandom_range(3, 12);
                first  = ($urandom_range(0, 9) != 0);
                while (left > 0 && span > 0) begin
                    queue_tick(span, first);
                    first = 1'b0;
                    left--;
                    if ($urandom_range(0, 19) == 0) begin
                        span = span + $urandom_range(0, 50000);
                        if (span > 2097151) span = 2097151;
                    end else begin
                        span = span - span / shrink - $urandom_range(1, 400);
                    end
                end
                tail = $urandom_range(1, 4);
                while (left > 0 && tail > 0) begin
                    near = $urandom_range(0, 1200);
                    queue_tick(near - 300, 1'b0);
                    tail--;
                    left--;
                end
            end
        end
    endtask

    initial begin : stimulus
        int target_v;
        int accel_v;
        int decel_v;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Reset values: a zero target cruises at zero beyond the default stop
        // distance, and the stop threshold itself is inclusive.
        queue_tick(2097151, 1'b0);
        queue_tick(512, 1'b1);
        queue_tick(513, 1'b0);
        queue_tick(-2097152, 1'b0);
        queue_tick(0, 1'b0);
        wait_idle();

        // Ramp up to the target, cap on it exactly, cruise, brake near the
        // end and stop at the threshold.
        program_profile(32'h4000, 32'h1000, 32'h0800, 100, 32'h0400, 512);
        queue_tick(100000, 1'b1);
        repeat (4) queue_tick(100000, 1'b0);
        queue_tick(5000, 1'b0);
        queue_tick(513, 1'b0);
        queue_tick(512, 1'b0);
        wait_idle();

        // A creep floor above the current speed raises it while braking.
        program_profile(32'h4000, 32'h1000, 32'h0800, 1, 32'h2000, 512);
        queue_tick(100000, 1'b1);
        queue_tick(10000, 1'b0);
        queue_tick(10000, 1'b0);
        wait_idle();

        // With a zero deceleration rate every tick beyond the stop distance
        // brakes, however far away.
        program_profile(32'h1000, 32'h1000, 32'h0800, 0, 32'h2000, 512);
        queue_tick(2097151, 1'b0);
        wait_idle();

        // A target below the current speed outside braking cruises at once.
        program_profile(32'h1000, 32'h1000, 32'h0800, 1, 0, 512);
        queue_tick(2097151, 1'b0);
        wait_idle();

        // Every register at its largest value.
        program_profile(32'hFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFF, 32'hFFFF);
        queue_tick(2097151, 1'b1);
        queue_tick(2097151, 1'b0);
        queue_tick(65535, 1'b0);
        queue_tick(65536, 1'b0);
        queue_tick(1000000, 1'b0);
        wait_idle();

        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            // Both sides idle, then neither, then only the receiver.
            tx_idle_on = (ph % 3) == 0;
            rx_idle_on = (ph % 3) != 1;
            if (ph == 1) begin
                program_profile(32'hFFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 32'hFFFFF, 32'hFFFF);
            end else if (ph == 2) begin
                program_profile(0, 0, 0, 0, 0, 0);
            end else if (ph % 2 == 1) begin
                program_profile(int'($urandom), int'($urandom), int'($urandom),
                                int'($urandom), int'($urandom), int'($urandom));
            end else begin
                // A plausible profile, scaled so that braking starts within
                // the distances that the moves cover.
                target_v = $urandom_range(32'h800, 32'h40000);
                accel_v  = $urandom_range(1, (target_v / 4 > 65535) ? 65535 : target_v / 4);
                decel_v  = $urandom_range(1, (target_v / 4 > 65535) ? 65535 : target_v / 4);
                program_profile(target_v, accel_v, decel_v, $urandom_range(1, 3000),
                                $urandom_range(0, 32'h800), $urandom_range(0, 4096));
            end
            queue_random_moves(ITEMS_PER_PHASE);
            wait_idle();
        end

        if (n_errors == 0 && ramp_out_queue.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
